// ===== sv/iut_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval union table package
// Widths, limits, status codes and the command and status bundles shared by
// the controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package iut_pkg;

    // Table depth and fixed-point time format.
    localparam int MAX_SPANS      = 16;
    localparam int TIME_FRAC_BITS = 8;
    localparam int TIME_W         = 13;
    localparam int IDX_W          = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int CNT_W          = $clog2(MAX_SPANS + 1);
    localparam int SPAN_COUNT_W   = 5;

    // First time that is no longer valid: 24.00 hours.
    localparam logic [TIME_W-1:0] TIME_LIMIT = TIME_W'(24 << TIME_FRAC_BITS);

    // Request kinds.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_REVERSED = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    step_query;
        logic    step_scan;
        logic    step_merge;
        logic    final_wr;
        logic    clr_k;
        logic    finish;
        t_status code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic accept;
        logic req_type;
        logic range_bad;
        logic reversed;
        logic full;
        logic scan_done;
        logic overlap;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/iut_if.sv =====
// ----------------------------------------------------------------------------
// Interval union table channels
// Request and response channels with a valid/ready handshake; one word moves
// at each edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface iut_req_if import iut_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [TIME_W-1:0] span_start;
    logic [TIME_W-1:0] span_end;
    logic [TIME_W-1:0] query_time;

    modport source (output valid, req_type, span_start, span_end, query_time,
                    input ready);
    modport sink   (input valid, req_type, span_start, span_end, query_time,
                    output ready);
endinterface

interface iut_rsp_if import iut_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    in_span;
    logic [1:0]              status;
    logic [SPAN_COUNT_W-1:0] span_count;

    modport source (output valid, in_span, status, span_count, input ready);
    modport sink   (input valid, in_span, status, span_count, output ready);
endinterface

// ===== sv/iut_ctrl.sv =====
// ----------------------------------------------------------------------------
// Interval union table controller
// Sequences the range checks, the table walks and the result handoff for
// one request word at a time.
// ----------------------------------------------------------------------------
module iut_ctrl import iut_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_QUERY,
        S_FSCAN,
        S_MERGE,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_code,  n_code;

    // Next state, next status code and the command bundle.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.range_bad) begin
                    n_code  = ST_RANGE;
                    n_state = S_RESULT;
                end else if (i_sts.req_type == REQ_QUERY) begin
                    n_code  = ST_OK;
                    n_state = S_QUERY;
                end else if (i_sts.reversed) begin
                    n_code  = ST_REVERSED;
                    n_state = S_RESULT;
                end else if (i_sts.full) begin
                    n_state = S_FSCAN;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_MERGE;
                end
            end
            S_QUERY: begin
                if (i_sts.scan_done) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.step_query = 1'b1;
                end
            end
            S_FSCAN: begin
                // A full table takes the add only if it merges with a span.
                if (!i_sts.scan_done) begin
                    o_cmd.step_scan = 1'b1;
                end else if (i_sts.overlap) begin
                    o_cmd.clr_k = 1'b1;
                    n_code      = ST_OK;
                    n_state     = S_MERGE;
                end else begin
                    n_code  = ST_FULL;
                    n_state = S_RESULT;
                end
            end
            S_MERGE: begin
                if (i_sts.scan_done) begin
                    o_cmd.final_wr = 1'b1;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.step_merge = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and status code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

// ===== sv/iut_dp.sv =====
// ----------------------------------------------------------------------------
// Interval union table datapath
// Holds the span table, the request, the pending span and the walk
// pointers, and the output register of the response channel.
// ----------------------------------------------------------------------------
module iut_dp import iut_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    iut_req_if.sink       i_req,
    iut_rsp_if.source     o_rsp
);

    // Span table, sorted ascending by start.
    logic [TIME_W-1:0] r_starts [MAX_SPANS];
    logic [TIME_W-1:0] r_ends   [MAX_SPANS];
    logic [CNT_W-1:0]  r_count;

    // Request and walk state.
    logic              r_req;
    logic [TIME_W-1:0] r_s, n_s;
    logic [TIME_W-1:0] r_e, n_e;
    logic [TIME_W-1:0] r_q;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_w, n_w;
    logic              r_ins, n_ins;
    logic              r_hit;
    logic              r_ovl;
    logic [TIME_W-1:0] r_rd_s;
    logic [TIME_W-1:0] r_rd_e;

    // Output register.
    logic              r_out_valid;
    logic              r_out_in_span;
    logic [1:0]        r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    logic              w_accept;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_idx;
    logic [TIME_W-1:0] w_wr_s;
    logic [TIME_W-1:0] w_wr_e;
    logic              w_before;
    logic              w_touch;

    assign i_req.ready = i_cmd.in_ready;
    assign w_accept    = i_req.valid & i_cmd.in_ready;

    // Walk pointer: cleared on a new request or a rescan, advanced by each step.
    always_comb begin
        n_k = r_k;
        if (w_accept || i_cmd.clr_k) begin
            n_k = '0;
        end else if (i_cmd.step_query || i_cmd.step_scan || i_cmd.step_merge) begin
            n_k = r_k + 1'b1;
        end
    end

    // The stored span lies wholly before the pending span, or touches it.
    assign w_before = (r_rd_e < r_s);
    assign w_touch  = (r_rd_s <= r_e);

    // Status toward the controller.
    always_comb begin
        o_sts.accept    = w_accept;
        o_sts.req_type  = r_req;
        o_sts.range_bad = (r_req == REQ_QUERY) ? (r_q >= TIME_LIMIT)
                                               : ((r_s >= TIME_LIMIT) ||
                                                  (r_e >= TIME_LIMIT));
        o_sts.reversed  = (r_s > r_e);
        o_sts.full      = (r_count >= CNT_W'(MAX_SPANS));
        o_sts.scan_done = (r_k == r_count);
        o_sts.overlap   = r_ovl;
        o_sts.out_free  = !r_out_valid || o_rsp.ready;
    end

    // Merge step: pass entries before the new span, absorb touching ones,
    // then emit the union and move the rest behind it through r_s/r_e.
    always_comb begin
        n_s      = r_s;
        n_e      = r_e;
        n_w      = r_w;
        n_ins    = r_ins;
        w_wr_en  = 1'b0;
        w_wr_idx = r_w[IDX_W-1:0];
        w_wr_s   = r_s;
        w_wr_e   = r_e;
        if (i_cmd.step_merge) begin
            if (r_ins) begin
                w_wr_en = 1'b1;
                n_s     = r_rd_s;
                n_e     = r_rd_e;
                n_w     = r_w + 1'b1;
            end else if (w_before) begin
                w_wr_en = 1'b1;
                w_wr_s  = r_rd_s;
                w_wr_e  = r_rd_e;
                n_w     = r_w + 1'b1;
            end else if (w_touch) begin
                n_s = (r_rd_s < r_s) ? r_rd_s : r_s;
                n_e = (r_rd_e > r_e) ? r_rd_e : r_e;
            end else begin
                w_wr_en = 1'b1;
                n_s     = r_rd_s;
                n_e     = r_rd_e;
                n_ins   = 1'b1;
                n_w     = r_w + 1'b1;
            end
        end else if (i_cmd.final_wr) begin
            w_wr_en = 1'b1;
        end
    end

    // Table write port, and a registered read of the entry the walk
    // pointer moves to. Writes land at or below the current pointer, so
    // the entry fetched for the next step is never the one being written.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_starts[w_wr_idx] <= w_wr_s;
            r_ends[w_wr_idx]   <= w_wr_e;
        end
        r_rd_s <= r_starts[n_k[IDX_W-1:0]];
        r_rd_e <= r_ends[n_k[IDX_W-1:0]];
    end

    // Request, pending span and walk registers.
    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (w_accept) begin
            r_req <= i_req.req_type;
            r_s   <= i_req.span_start;
            r_e   <= i_req.span_end;
            r_q   <= i_req.query_time;
            r_w   <= '0;
            r_ins <= 1'b0;
            r_hit <= 1'b0;
            r_ovl <= 1'b0;
        end else begin
            r_s   <= n_s;
            r_e   <= n_e;
            r_w   <= n_w;
            r_ins <= n_ins;
            if (i_cmd.step_query && (r_rd_s <= r_q) && (r_q <= r_rd_e)) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.step_scan && (r_rd_e >= r_s) && w_touch) begin
                r_ovl <= 1'b1;
            end
        end
    end

    // Stored span count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.final_wr) begin
            r_count <= r_w + 1'b1;
        end
    end

    // Response output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_in_span <= r_hit;
            r_out_status  <= i_cmd.code;
            r_out_count   <= r_count;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.in_span    = r_out_in_span;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.span_count = SPAN_COUNT_W'(r_out_count);

endmodule

// ===== sv/interval_union_table_unit.sv =====
// ----------------------------------------------------------------------------
// Interval union table unit
// Sorted table of disjoint closed time spans with merging add and point query.
// ----------------------------------------------------------------------------
// The unit handles one request word at a time and returns one response word
// for each. Times are hours times 256 and must lie below 24.00 hours. A query
// walks the stored spans one per cycle. An add walks and rewrites the table in
// one pass, one entry per cycle through its single read port; when the table
// already holds all 16 spans it first makes an extra walk of the table to see
// whether the new span merges. Out-of-range and reversed requests respond
// without a walk of the table. The response sits in an output register, so
// the next request is taken while the last response is still waiting.
module interval_union_table_unit import iut_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iut_req_if.sink   i_req,
    iut_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    iut_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Table, walk logic and output register.
    iut_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Interval union table unit testbench
// Drives add and query words into the unit and checks every response word
// against a span table kept in the bench. Directed tests cover the empty
// table, range and reversal rejects, touching and one-tick-apart spans and a
// full table. Random traffic then runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import iut_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int TIME_MAX    = 24 << TIME_FRAC_BITS;
    localparam int SLOT_TICKS  = TIME_MAX / MAX_SPANS;

    // One response word as the bench expects it.
    typedef struct packed {
        logic                    in_span;
        t_status                 status;
        logic [SPAN_COUNT_W-1:0] span_count;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    iut_req_if req_if ();
    iut_rsp_if rsp_if ();

    interval_union_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Span table as the bench tracks it, sorted ascending.
    logic [TIME_W-1:0] held_lo [MAX_SPANS];
    logic [TIME_W-1:0] held_hi [MAX_SPANS];
    int                held_count = 0;

    t_answer pending_answers [$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int add_count       = 0;
    int query_count     = 0;
    int hit_count       = 0;
    int peak_count      = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp an integer time into the valid range.
    function automatic logic [TIME_W-1:0] to_time(int t);
        if (t < 0) begin
            return '0;
        end
        if (t > TIME_MAX - 1) begin
            return TIME_W'(TIME_MAX - 1);
        end
        return TIME_W'(t);
    endfunction

    // Apply one request to the tracked table and return the response it earns.
    function automatic t_answer merge_or_lookup(logic kind, logic [TIME_W-1:0] s_in,
                                                logic [TIME_W-1:0] e_in,
                                                logic [TIME_W-1:0] q);
        t_answer           a;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        int                lo;
        int                hi;
        int                merged;
        int                k;
        a        = '0;
        a.status = ST_OK;
        s        = s_in;
        e        = e_in;
        if (kind == REQ_ADD) begin
            if (s >= TIME_LIMIT || e >= TIME_LIMIT) begin
                a.status = ST_RANGE;
            end else if (s > e) begin
                a.status = ST_REVERSED;
            end else begin
                // Skip spans that end before the new start, then absorb every
                // span that starts at or before the new end.
                lo = 0;
                while (lo < held_count && held_hi[lo] < s) lo++;
                hi = lo;
                while (hi < held_count && held_lo[hi] <= e) begin
                    if (held_lo[hi] < s) s = held_lo[hi];
                    if (held_hi[hi] > e) e = held_hi[hi];
                    hi++;
                end
                merged = hi - lo;
                if (merged == 0 && held_count >= MAX_SPANS) begin
                    a.status = ST_FULL;
                end else begin
                    // Move the tail so that it follows the union at slot lo.
                    if (merged == 0) begin
                        for (k = held_count; k > lo; k--) begin
                            held_lo[k] = held_lo[k-1];
                            held_hi[k] = held_hi[k-1];
                        end
                    end else begin
                        for (k = 0; k < held_count - hi; k++) begin
                            held_lo[lo+1+k] = held_lo[hi+k];
                            held_hi[lo+1+k] = held_hi[hi+k];
                        end
                    end
                    held_lo[lo] = s;
                    held_hi[lo] = e;
                    held_count  = held_count - merged + 1;
                end
            end
        end else if (q >= TIME_LIMIT) begin
            a.status = ST_RANGE;
        end else begin
            for (k = 0; k < held_count; k++) begin
                if (held_lo[k] <= q && q <= held_hi[k]) a.in_span = 1'b1;
            end
        end
        a.span_count = SPAN_COUNT_W'(held_count);
        return a;
    endfunction

    // Report one mismatch; only the first few dozen are printed.
    task automatic report_mismatch(string what, int want, int got);
        if (error_count < 40) begin
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        end
        error_count++;
    endtask

    // Send one request word, with an optional idle gap ahead of it.
    task automatic send_request(logic kind, logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                                logic [TIME_W-1:0] q);
        t_answer a;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.span_start <= s;
        req_if.span_end   <= e;
        req_if.query_time <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        a = merge_or_lookup(kind, s, e, q);
        pending_answers.push_back(a);
        if (kind == REQ_ADD) add_count++;
        else query_count++;
        if (a.in_span) hit_count++;
        status_seen[a.status]++;
        if (held_count > peak_count) peak_count = held_count;
    endtask

    // Compare one response word with the oldest expectation.
    task automatic check_answer();
        t_answer want;
        if (pending_answers.size() == 0) begin
            report_mismatch("response word with nothing pending", 0, 1);
            return;
        end
        want = pending_answers.pop_front();
        if (rsp_if.in_span !== want.in_span) begin
            report_mismatch("in_span", want.in_span, rsp_if.in_span);
        end
        if (rsp_if.status !== want.status) begin
            report_mismatch("status", want.status, rsp_if.status);
        end
        if (rsp_if.span_count !== want.span_count) begin
            report_mismatch("span_count", want.span_count, rsp_if.span_count);
        end
    endtask

    // Response side: check accepted words and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) check_answer();
            rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Random endpoint of a stored span, or a random time on an empty table.
    function automatic int pick_edge();
        int k;
        if (held_count == 0) return $urandom_range(TIME_MAX - 1);
        k = $urandom_range(held_count - 1);
        return $urandom_range(1) ? int'(held_hi[k]) : int'(held_lo[k]);
    endfunction

    // Queries on an empty table at the edges of the time range.
    task automatic test_empty_table();
        send_request(REQ_QUERY, '0, '0, '0);
        send_request(REQ_QUERY, '1, '1, TIME_W'(TIME_MAX - 1));
        send_request(REQ_QUERY, '0, '0, TIME_W'(TIME_MAX));
        send_request(REQ_QUERY, '0, '0, '1);
    endtask

    // Out-of-range times win over reversal; reversed spans are dropped.
    task automatic test_range_and_reversed();
        send_request(REQ_ADD, TIME_W'(TIME_MAX), TIME_W'(10), '0);
        send_request(REQ_ADD, TIME_W'(10), '1, '0);
        send_request(REQ_ADD, '1, '0, '0);
        send_request(REQ_ADD, TIME_W'(200), TIME_W'(100), '0);
        send_request(REQ_ADD, TIME_W'(TIME_MAX - 1), '0, '0);
    endtask

    // Spans sharing an endpoint merge; spans one tick apart stay separate.
    task automatic test_touch_and_gap();
        send_request(REQ_ADD, TIME_W'(100), TIME_W'(200), '0);
        send_request(REQ_ADD, TIME_W'(200), TIME_W'(300), '0);
        send_request(REQ_ADD, TIME_W'(301), TIME_W'(400), '0);
        send_request(REQ_QUERY, '0, '0, TIME_W'(300));
        send_request(REQ_QUERY, '0, '0, TIME_W'(301));
        send_request(REQ_QUERY, '0, '0, TIME_W'(99));
        send_request(REQ_QUERY, '0, '0, TIME_W'(401));
        send_request(REQ_ADD, '0, '0, '0);
        send_request(REQ_ADD, TIME_W'(TIME_MAX - 1), TIME_W'(TIME_MAX - 1), '0);
        send_request(REQ_QUERY, '0, '0, '0);
        send_request(REQ_QUERY, '0, '0, TIME_W'(TIME_MAX - 1));
    endtask

    // One add swallowing several stored spans.
    task automatic test_engulf();
        send_request(REQ_ADD, TIME_W'(50), TIME_W'(350), '0);
        send_request(REQ_ADD, TIME_W'(40), TIME_W'(450), '0);
        send_request(REQ_QUERY, '0, '0, TIME_W'(450));
    endtask

    // Fill the table, then hit it with rejects, a merge and a bridge.
    task automatic test_table_full();
        int k;
        int s;
        k = 2;
        while (held_count < MAX_SPANS && k < MAX_SPANS - 1) begin
            s = k * SLOT_TICKS + $urandom_range(300);
            send_request(REQ_ADD, to_time(s), to_time(s + $urandom_range(8)), '0);
            k++;
        end
        s = (MAX_SPANS - 1) * SLOT_TICKS + 100;
        send_request(REQ_ADD, to_time(s), to_time(s + 10), '0);
        send_request(REQ_ADD, to_time(s + 40), to_time(s + 30), '0);
        send_request(REQ_ADD, TIME_W'(TIME_MAX + 56), TIME_W'(TIME_MAX + 156), '0);
        send_request(REQ_QUERY, '0, '0, to_time(s));
        send_request(REQ_ADD, held_hi[1], to_time(held_hi[1] + 3), '0);
        send_request(REQ_ADD, held_hi[2], held_lo[3], '0);
        send_request(REQ_ADD, to_time(s), to_time(s + 10), '0);
    endtask

    // Mostly well-formed adds and queries near stored edges, with some noise.
    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_words);
        int                n;
        int                roll;
        int                s;
        int                e;
        int                off;
        logic              kind;
        logic [TIME_W-1:0] fs;
        logic [TIME_W-1:0] fe;
        logic [TIME_W-1:0] fq;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (n = 0; n < n_words; n++) begin
            roll = $urandom_range(99);
            fs   = TIME_W'($urandom);
            fe   = TIME_W'($urandom);
            fq   = TIME_W'($urandom);
            if (roll < 25) begin
                // Short span anywhere.
                s = $urandom_range(TIME_MAX - 1);
                e = s + $urandom_range(8);
                send_request(REQ_ADD, to_time(s), to_time(e), fq);
            end else if (roll < 45) begin
                // Short span placed against an existing edge.
                off = $urandom_range(4);
                if ($urandom_range(1)) begin
                    s = pick_edge() + off - 2;
                    e = s + $urandom_range(8);
                end else begin
                    e = pick_edge() + off - 2;
                    s = e - $urandom_range(8);
                end
                send_request(REQ_ADD, to_time(s), to_time(e), fq);
            end else if (roll < 47) begin
                // Wide span that may bridge several stored spans.
                s = $urandom_range(TIME_MAX - 1);
                e = s + $urandom_range(700);
                send_request(REQ_ADD, to_time(s), to_time(e), fq);
            end else if (roll < 75) begin
                // Query on or next to an edge, or anywhere valid.
                off = $urandom_range(2);
                if ($urandom_range(1)) s = pick_edge() + off - 1;
                else s = $urandom_range(TIME_MAX - 1);
                send_request(REQ_QUERY, fs, fe, to_time(s));
            end else if (roll < 83) begin
                // Reversed span with valid times.
                s = $urandom_range(TIME_MAX - 1, 1);
                e = $urandom_range(s - 1);
                send_request(REQ_ADD, to_time(s), to_time(e), fq);
            end else if (roll < 95) begin
                // Raw noise over every bit of every field.
                kind = 1'($urandom_range(1));
                send_request(kind, fs, fe, fq);
            end else begin
                // Times right at the 24-hour limit.
                kind = 1'($urandom_range(1));
                s    = TIME_MAX - 2 + $urandom_range(3);
                e    = TIME_MAX - 2 + $urandom_range(3);
                off  = TIME_MAX - 2 + $urandom_range(3);
                send_request(kind, TIME_W'(s), TIME_W'(e), TIME_W'(off));
            end
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_ADD;
        req_if.span_start <= '0;
        req_if.span_end   <= '0;
        req_if.query_time <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_range_and_reversed();
        test_touch_and_gap();
        test_engulf();
        test_table_full();
        test_random_traffic(0, 0, 250);
        test_random_traffic(48, 0, 250);
        test_random_traffic(0, 48, 250);
        test_random_traffic(30, 30, 250);

        // Drain the responses, then let the unit settle.
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d adds and %0d queries (%0d hits), table peaked at %0d spans.",
                 add_count, query_count, hit_count, peak_count);
        $display("Status ok/range/full/reversed: %0d/%0d/%0d/%0d, mismatches: %0d.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
                 status_seen[ST_REVERSED], error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
